[rtl/book_sequence_sync_controller_unit_assert.svh]
// Assertion macros used by the decision stage (bssc_back) of the sync controller.
`ifndef BOOK_SEQUENCE_SYNC_CONTROLLER_UNIT_ASSERT_SVH
`define BOOK_SEQUENCE_SYNC_CONTROLLER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BSSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define BSSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

[rtl/bssc_pkg.sv]
// ----------------------------------------------------------------------------
// bssc_pkg
// Shared codes and types of the book sequence sync controller.
// ----------------------------------------------------------------------------
package bssc_pkg;

    // message kinds (tuser)
    localparam logic [1:0] OP_WS_SNAP   = 2'd0;
    localparam logic [1:0] OP_REST_SNAP = 2'd1;
    localparam logic [1:0] OP_INCR      = 2'd2;
    localparam logic [1:0] OP_UNKNOWN   = 2'd3;

    // sync modes
    localparam logic [1:0] MODE_WAIT_SNAP   = 2'd0;
    localparam logic [1:0] MODE_WAIT_BRIDGE = 2'd1;
    localparam logic [1:0] MODE_SYNCED      = 2'd2;

    // resync reasons
    localparam logic [3:0] RSN_NONE          = 4'd0;
    localparam logic [3:0] RSN_NO_SEQ        = 4'd1;
    localparam logic [3:0] RSN_GAP           = 4'd2;
    localparam logic [3:0] RSN_CROSSED       = 4'd3;
    localparam logic [3:0] RSN_MISSING_CS    = 4'd4;
    localparam logic [3:0] RSN_MISMATCH      = 4'd5;
    localparam logic [3:0] RSN_INVALID       = 4'd6;
    localparam logic [3:0] RSN_REQUIRED_CS   = 4'd7;
    localparam logic [3:0] RSN_SNAP_MISMATCH = 4'd8;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_CS_ENABLE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOW_GAP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STRICT_CHECKSUM = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VENUE_DECLARES  = 3'd4;

    typedef struct packed {
        logic is_snap;
        logic is_ws;
        logic is_incr;
        logic has_seq;
        logic cs_present;
        logic cs_match;
        logic crossed;
        logic book_ok;
    } item_class_t;

    typedef struct packed {
        logic cs_enable;
        logic allow_gap;
        logic strict_checksum;
        logic venue_declares_checksum;
    } cfg_flags_t;

endpackage

[rtl/book_sequence_sync_controller_unit.sv]
// ----------------------------------------------------------------------------
// book_sequence_sync_controller_unit
// Feed sync controller: decides apply / ignore / resync per book message.
// ----------------------------------------------------------------------------
// Result path: an accepted message is written into the queue, then decided and registered in the output register.
// Throughput: one message per cycle while m_tready is high; decision stage updates sync state on each popped message.
// A two-entry queue between classifier and decision stage absorbs output stalls.
// Reset: rst_n async active low clears config, sync mode, expected seq, counter
// and the queue; ready right after reset, no clearing pass.
module book_sequence_sync_controller_unit
    import bssc_pkg::*;
#(
    parameter int SEQ_BITS    = 64,
    parameter int PERIOD_BITS = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    // config write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [PERIOD_BITS-1:0] cfg_data,
    // message input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // first seq, last seq, checksum present, checksum match, crossed,
    // book valid, zero pad
    input  logic [((2*SEQ_BITS+4+7)/8)*8-1:0] s_tdata,
    // opcode
    input  logic [1:0]             s_tuser,
    // decision output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // apply, resync, resync_reason[3:0], mode_after[1:0],
    // next_expected, zero pad
    output logic [((8+SEQ_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int DATA_W = ((2*SEQ_BITS + 4 + 7) / 8) * 8;
    localparam int OUT_W  = ((8 + SEQ_BITS + 7) / 8) * 8;
    localparam int CLS_W  = $bits(item_class_t);
    localparam int Q_W    = CLS_W + 3 * SEQ_BITS;

    cfg_flags_t             cfg_flags_reg;
    logic [PERIOD_BITS-1:0] check_period_reg;

    item_class_t            f_cls;
    logic [SEQ_BITS-1:0]    f_first;
    logic [SEQ_BITS-1:0]    f_last;
    logic [SEQ_BITS-1:0]    f_last_inc;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_full;
    logic                   q_empty;
    logic [Q_W-1:0]         q_head;
    item_class_t            b_cls;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_flags_reg    <= '0;
            check_period_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_CS_ENABLE:       cfg_flags_reg.cs_enable       <= cfg_data[0];
                CFG_ALLOW_GAP:       cfg_flags_reg.allow_gap       <= cfg_data[0];
                CFG_CHECK_PERIOD:    check_period_reg              <= cfg_data;
                CFG_STRICT_CHECKSUM: cfg_flags_reg.strict_checksum <= cfg_data[0];
                CFG_VENUE_DECLARES:  cfg_flags_reg.venue_declares_checksum <= cfg_data[0];
                default:             ;
            endcase
        end
    end

    bssc_front #(
        .SEQ_BITS (SEQ_BITS),
        .DATA_W   (DATA_W)
    ) u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .q_full     (q_full),
        .q_push     (q_push),
        .cls        (f_cls),
        .seq_lo     (f_first),
        .seq_hi     (f_last),
        .seq_hi_inc (f_last_inc)
    );

    bssc_queue #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_cls, f_first, f_last, f_last_inc}),
        .pop       (q_pop),
        .head_data (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign b_cls = item_class_t'(q_head[Q_W-1:3*SEQ_BITS]);

    bssc_back #(
        .SEQ_BITS    (SEQ_BITS),
        .PERIOD_BITS (PERIOD_BITS),
        .OUT_W       (OUT_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_flags_reg),
        .check_period (check_period_reg),
        .q_empty      (q_empty),
        .q_pop        (q_pop),
        .cls          (b_cls),
        .seq_lo       (q_head[3*SEQ_BITS-1:2*SEQ_BITS]),
        .seq_hi       (q_head[2*SEQ_BITS-1:SEQ_BITS]),
        .seq_hi_inc   (q_head[SEQ_BITS-1:0]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

[rtl/bssc_front.sv]
// ----------------------------------------------------------------------------
// bssc_front
// Input side: accepts messages, decodes the kind and precomputes seq_hi + 1.
// ----------------------------------------------------------------------------
module bssc_front
    import bssc_pkg::*;
#(
    parameter int SEQ_BITS = 64,
    parameter int DATA_W   = 136
)
(
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [DATA_W-1:0]   s_tdata,
    input  logic [1:0]          s_tuser,
    input  logic                q_full,
    output logic                q_push,
    output item_class_t         cls,
    output logic [SEQ_BITS-1:0] seq_lo,
    output logic [SEQ_BITS-1:0] seq_hi,
    output logic [SEQ_BITS-1:0] seq_hi_inc
);

    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    assign seq_lo     = s_tdata[SEQ_BITS-1:0];
    assign seq_hi     = s_tdata[2*SEQ_BITS-1:SEQ_BITS];
    assign seq_hi_inc = seq_hi + SEQ_BITS'(1);

    always_comb
    begin
        cls            = '0;
        cls.has_seq    = (seq_hi != '0);
        cls.cs_present = s_tdata[2*SEQ_BITS];
        cls.cs_match   = s_tdata[2*SEQ_BITS+1];
        cls.crossed    = s_tdata[2*SEQ_BITS+2];
        cls.book_ok    = s_tdata[2*SEQ_BITS+3];
        unique case (s_tuser)
            OP_WS_SNAP:
            begin
                cls.is_snap = 1'b1;
                cls.is_ws   = 1'b1;
            end
            OP_REST_SNAP: cls.is_snap = 1'b1;
            OP_INCR:      cls.is_incr = 1'b1;
            default:      ;     // unknown kind: kind flags low, ignored downstream
        endcase
    end

endmodule

[rtl/bssc_queue.sv]
// ----------------------------------------------------------------------------
// bssc_queue
// Short FIFO decoupling the classifier from the decision stage.
// ----------------------------------------------------------------------------
module bssc_queue
#(
    parameter int WIDTH = 200,
    parameter int DEPTH = 2
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign head_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
    end

endmodule

[rtl/bssc_back.sv]
// ----------------------------------------------------------------------------
// bssc_back
// Decision stage: sync mode, expected sequence and check counter; registered
// result toward the master side.
// ----------------------------------------------------------------------------
`include "book_sequence_sync_controller_unit_assert.svh"

module bssc_back
    import bssc_pkg::*;
#(
    parameter int SEQ_BITS    = 64,
    parameter int PERIOD_BITS = 16,
    parameter int OUT_W       = 72
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  cfg_flags_t             cfg,
    input  logic [PERIOD_BITS-1:0] check_period,
    input  logic                   q_empty,
    output logic                   q_pop,
    input  item_class_t            cls,
    input  logic [SEQ_BITS-1:0]    seq_lo,
    input  logic [SEQ_BITS-1:0]    seq_hi,
    input  logic [SEQ_BITS-1:0]    seq_hi_inc,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_W-1:0]       m_tdata
);

    logic [1:0]             mode_reg,   mode_next;
    logic [SEQ_BITS-1:0]    exp_reg,    exp_next;
    logic [PERIOD_BITS-1:0] cnt_reg,    cnt_next;
    logic                   out_valid_reg;
    logic                   apply_reg,  apply_next;
    logic                   resync_reg, resync_next;
    logic [3:0]             reason_reg, reason_next;
    logic [1:0]             mode_out_reg;
    logic [SEQ_BITS-1:0]    exp_out_reg;
    logic [PERIOD_BITS-1:0] cnt_inc;
    logic                   period_hit;
    logic                   cs_on;

    assign q_pop   = !q_empty && (!out_valid_reg || m_tready);
    assign cs_on   = cfg.cs_enable;
    assign cnt_inc = cnt_reg + PERIOD_BITS'(1);
    assign period_hit = (check_period != '0) && (cnt_inc >= check_period);

    always_comb
    begin
        apply_next  = 1'b0;
        resync_next = 1'b0;
        reason_next = RSN_NONE;
        mode_next   = mode_reg;
        exp_next    = exp_reg;
        cnt_next    = cnt_reg;

        if (cls.is_snap)
        begin
            apply_next = 1'b1;
            cnt_next   = '0;
            exp_next   = seq_hi_inc;
            if (cs_on && cls.cs_present && !cls.cs_match)
            begin
                resync_next = 1'b1;
                reason_next = RSN_SNAP_MISMATCH;
            end
            else
                mode_next = cls.is_ws ? MODE_SYNCED : MODE_WAIT_BRIDGE;
        end
        else if (cls.is_incr &&
                 (mode_reg == MODE_WAIT_BRIDGE || mode_reg == MODE_SYNCED))
        begin
            if (!cls.has_seq && !cs_on)
            begin
                resync_next = 1'b1;
                reason_next = RSN_NO_SEQ;
            end
            else if (cls.has_seq && (seq_hi < exp_reg))
            begin
                // outdated: dropped without any change
            end
            else if (cls.has_seq && (seq_lo > exp_reg) && !cfg.allow_gap)
            begin
                resync_next = 1'b1;
                reason_next = RSN_GAP;
            end
            else
            begin
                apply_next = 1'b1;
                if (cls.has_seq)
                    exp_next = seq_hi_inc;
                if (mode_reg == MODE_WAIT_BRIDGE)
                begin
                    // bridge message: no periodic or strict checks
                    mode_next = MODE_SYNCED;
                    if (cls.crossed)
                        reason_next = RSN_CROSSED;
                    else if (cs_on && !cls.cs_present)
                        reason_next = RSN_MISSING_CS;
                    else if (cs_on && !cls.cs_match)
                        reason_next = RSN_MISMATCH;
                end
                else if (cls.crossed)
                    reason_next = RSN_CROSSED;
                else
                begin
                    if (check_period != '0)
                        cnt_next = period_hit ? '0 : cnt_inc;
                    if (period_hit && !cls.book_ok)
                        reason_next = RSN_INVALID;
                    else if (cs_on && !cls.cs_present)
                        reason_next = RSN_MISSING_CS;
                    else if (cs_on && !cls.cs_match)
                        reason_next = RSN_MISMATCH;
                    else if (cfg.strict_checksum && cfg.venue_declares_checksum &&
                             !cs_on && !cls.cs_present)
                        reason_next = RSN_REQUIRED_CS;
                end
                resync_next = (reason_next != RSN_NONE);
            end
        end

        if (resync_next)
        begin
            mode_next = MODE_WAIT_SNAP;
            exp_next  = '0;
            cnt_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_WAIT_SNAP;
            exp_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                mode_reg      <= mode_next;
                exp_reg       <= exp_next;
                cnt_reg       <= cnt_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            apply_reg    <= apply_next;
            resync_reg   <= resync_next;
            reason_reg   <= reason_next;
            mode_out_reg <= mode_next;
            exp_out_reg  <= exp_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb
    begin
        m_tdata                 = '0;
        m_tdata[0]              = apply_reg;
        m_tdata[1]              = resync_reg;
        m_tdata[5:2]            = reason_reg;
        m_tdata[7:6]            = mode_out_reg;
        m_tdata[SEQ_BITS+7:8]   = exp_out_reg;
    end

    `BSSC_ASSERT_IMPL(a_wait_snap_clear, clk, rst_n, mode_reg == MODE_WAIT_SNAP,
        exp_reg == '0 && cnt_reg == '0)
    `BSSC_ASSERT_IMPL(a_resync_result_clear, clk, rst_n, out_valid_reg && resync_reg,
        mode_out_reg == MODE_WAIT_SNAP && exp_out_reg == '0)
    `BSSC_ASSERT_IMPL(a_reason_iff_resync, clk, rst_n, out_valid_reg,
        resync_reg == (reason_reg != RSN_NONE))
    `BSSC_ASSERT_NEXT(a_pop_gives_result, clk, rst_n, q_pop,
        out_valid_reg && mode_out_reg == mode_reg && exp_out_reg == exp_reg)

endmodule
